// File: hw/rtl/ilid_pkg.sv
// Package for the indexed list core: field widths, operation and status codes,
// controller states and the control word broadcast along the row of cells.
// Depends on nothing; imported by every other file of the block.
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int POS_W        = 8;
    localparam int VAL_W        = 32;
    localparam int ST_W         = 2;
    localparam int LEN_W        = 9;
    localparam int GROUP_SIZE   = 16;

    localparam int IN_BITS  = OP_W + POS_W + VAL_W;
    localparam int OUT_BITS = VAL_W + ST_W + LEN_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] NO_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_END   = 3'd2,
        OP_INS_POS   = 3'd3,
        OP_DELETE    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER
    } state_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic             read_ok;
        status_t          status;
        logic [LEN_W-1:0] length;
    } res_meta_t;

endpackage : ilid_pkg

`default_nettype wire

// File: hw/rtl/ilid_cell.sv
// One list cell: holds one entry and takes the word of either neighbour or a
// new value on insert/delete. Depends on ilid_pkg.
`default_nettype none

module ilid_cell
    import ilid_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [VAL_W-1:0] left_val,
    input  wire logic [VAL_W-1:0] right_val,
    output logic      [VAL_W-1:0] value,
    output logic      [VAL_W-1:0] rd_val
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (IDX > ctrl.pos)
            begin
                value_next = left_val;
            end
            else if (IDX == ctrl.pos)
            begin
                value_next = ctrl.value;
            end
        end
        else if (ctrl.del)
        begin
            if (IDX >= ctrl.pos)
            begin
                value_next = right_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value  = value_reg;
    assign rd_val = (IDX == ctrl.pos) ? value_reg : '0;

endmodule : ilid_cell

`default_nettype wire

// File: hw/rtl/ilid_ctrl.sv
// Request controller: takes a word, decides status and length, drives the
// cell row and sequences the read gather. Depends on ilid_pkg.
`default_nettype none

module ilid_ctrl
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OP_W-1:0]  in_op,
    input  wire logic [POS_W-1:0] in_pos,
    input  wire logic [VAL_W-1:0] in_value,
    input  wire logic             out_free,
    output cell_ctrl_t            cell_ctrl,
    output logic                  gather_en,
    output logic                  out_load,
    output res_meta_t             meta
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    res_meta_t        meta_reg;
    res_meta_t        meta_next;

    logic             full;
    logic             do_ins;
    logic             do_del;
    logic [POS_W-1:0] ins_pos;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] count_ext;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = LEN_W'(pos_reg);
    assign count_ext = LEN_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_GATHER;
            end
            S_GATHER:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        gather_en = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EXEC:
            begin
                gather_en = 1'b1;
            end
            S_GATHER:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        do_ins            = 1'b0;
        do_del            = 1'b0;
        ins_pos           = pos_reg;
        meta_next.read_ok = 1'b0;
        meta_next.status  = ST_DONE;
        case (op_t'(op_reg))
            OP_READ:
            begin
                if (pos_ext < count_ext)
                begin
                    meta_next.read_ok = 1'b1;
                end
                else
                begin
                    meta_next.status = ST_RANGE;
                end
            end
            OP_INS_FRONT:
            begin
                ins_pos = '0;
                if (full)
                begin
                    meta_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_INS_END:
            begin
                ins_pos = POS_W'(count_reg);
                if (full)
                begin
                    meta_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_INS_POS:
            begin
                if (pos_ext > count_ext)
                begin
                    meta_next.status = ST_RANGE;
                end
                else if (full)
                begin
                    meta_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (pos_ext >= count_ext)
                begin
                    meta_next.status = ST_RANGE;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            default:
            begin
                meta_next.status = ST_RANGE;
            end
        endcase

        count_next = count_reg;
        if (gather_en && do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (gather_en && do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        meta_next.length = LEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= in_op;
            pos_reg <= in_pos;
            val_reg <= in_value;
        end
        if (gather_en)
        begin
            meta_reg <= meta_next;
        end
    end

    assign cell_ctrl.ins   = gather_en && do_ins;
    assign cell_ctrl.del   = gather_en && do_del;
    assign cell_ctrl.pos   = ins_pos;
    assign cell_ctrl.value = val_reg;
    assign meta            = meta_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_ctrl.ins && cell_ctrl.del))
        else $error("insert and delete together");

    a_cmd_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.ins || cell_ctrl.del) |-> state_reg == S_EXEC)
        else $error("cell command outside execute");

    a_exec_then_gather: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_GATHER)
        else $error("execute not followed by gather");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg) == S_EXEC)
        else $error("count changed outside execute");

endmodule : ilid_ctrl

`default_nettype wire

// File: hw/rtl/indexed_list_insert_delete_core.sv
// Top level of the indexed list core: controller, row of cells, read gather
// tree and output register. Depends on ilid_pkg, ilid_ctrl and ilid_cell.
//
//   channel  | direction | tdata fields (lowest bit up)
//   s_axis   | in        | op[2:0], position[10:3], value[42:11], zero fill to 48
//   m_axis   | out       | read_value[31:0], status[33:32], length_now[42:34], fill
//
// Each word passes through accept, cell update and read gather in turn.
// The next word is accepted in the cycle after the result is registered, so
// a result may wait in the output register while the next word is worked on.
// The gather holds while the output register still carries an untaken word.
// rst_n clears the length and the control state; entries are not cleared.
`default_nettype none

module indexed_list_insert_delete_core
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op, position, value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata    // read_value, status, length_now
);

    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    cell_ctrl_t       cell_ctrl;
    res_meta_t        meta;
    logic             gather_en;
    logic             out_load;
    logic             out_free;
    logic [VAL_W-1:0] cell_val [CAPACITY];
    logic [VAL_W-1:0] cell_rd  [CAPACITY];
    logic [VAL_W-1:0] group_reg  [NUM_GROUPS];
    logic [VAL_W-1:0] group_next [NUM_GROUPS];
    logic [VAL_W-1:0] gathered;

    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_data_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[OP_W-1:0]),
        .in_pos    (s_axis_tdata[OP_W+POS_W-1:OP_W]),
        .in_value  (s_axis_tdata[IN_BITS-1:OP_W+POS_W]),
        .out_free  (out_free),
        .cell_ctrl (cell_ctrl),
        .gather_en (gather_en),
        .out_load  (out_load),
        .meta      (meta)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_inner_l
            assign left_val = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_inner_r
            assign right_val = cell_val[i+1];
        end

        ilid_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .left_val  (left_val),
            .right_val (right_val),
            .value     (cell_val[i]),
            .rd_val    (cell_rd[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | cell_rd[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gather_en)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb
    begin
        gathered = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            gathered = gathered | group_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {meta.length, meta.status,
                             (meta.read_ok ? gathered : NO_VALUE)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule : indexed_list_insert_delete_core

`default_nettype wire

// File: dv/indexed_list_checker.sv
`timescale 1ns / 1ps
// Checker for the indexed list core: watches both stream channels, keeps a shadow
// of the list to predict each reply word and compares it field by field.
// Depends on ilid_pkg for widths, operation and status codes.

module indexed_list_checker
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op, position, value
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_value, status, length_now
    output int unsigned                 errors,
    output int unsigned                 outstanding
);

    typedef struct {
        logic [VAL_W-1:0] read_value;
        status_t          status;
        logic [LEN_W-1:0] length_now;
    } list_reply_t;

    logic [VAL_W-1:0] shadow_list [CAPACITY];
    int unsigned      shadow_len;
    list_reply_t      reply_q [$];

    function automatic status_t place_entry(int unsigned pos, logic [VAL_W-1:0] val);
        int unsigned i;
        if (shadow_len >= CAPACITY)
            return ST_FULL;
        for (i = shadow_len; i > pos; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = val;
        shadow_len++;
        return ST_DONE;
    endfunction

    function automatic list_reply_t apply_request(logic [OP_W-1:0] op,
                                                  logic [POS_W-1:0] pos,
                                                  logic [VAL_W-1:0] val);
        list_reply_t r;
        int unsigned i;
        r.read_value = NO_VALUE;
        r.status     = ST_DONE;
        case (op)
            OP_READ:
            begin
                if (pos < shadow_len)
                    r.read_value = shadow_list[pos];
                else
                    r.status = ST_RANGE;
            end
            OP_INS_FRONT:
                r.status = place_entry(0, val);
            OP_INS_END:
                r.status = place_entry(shadow_len, val);
            OP_INS_POS:
            begin
                if (pos > shadow_len)
                    r.status = ST_RANGE;
                else
                    r.status = place_entry(32'(pos), val);
            end
            OP_DELETE:
            begin
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = 32'(pos); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.length_now = LEN_W'(shadow_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        list_reply_t got;
        list_reply_t want;
        if (!rst_n)
        begin
            reply_q.delete();
            shadow_len  = 0;
            outstanding = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                reply_q.push_back(apply_request(s_axis_tdata[OP_W-1:0],
                                                s_axis_tdata[OP_W +: POS_W],
                                                s_axis_tdata[OP_W+POS_W +: VAL_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_value = m_axis_tdata[VAL_W-1:0];
                got.status     = status_t'(m_axis_tdata[VAL_W +: ST_W]);
                got.length_now = m_axis_tdata[VAL_W+ST_W +: LEN_W];
                if (reply_q.size() == 0)
                begin
                    $error("reply word with no request pending: read_value %h status %0d length_now %0d",
                           got.read_value, got.status, got.length_now);
                    errors++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.length_now !== want.length_now)
                    begin
                        $error("length_now: expected %0d, got %0d", want.length_now, got.length_now);
                        errors++;
                    end
                end
            end
            outstanding = reply_q.size();
        end
    end

endmodule : indexed_list_checker

// File: dv/tb_indexed_list_insert_delete_core.sv
`timescale 1ns / 1ps
// Testbench top for the indexed list core: clock, reset, request stimulus with
// bursts and gaps, a stalling reply sink, watchdog and verdict.
// Depends on ilid_pkg, indexed_list_insert_delete_core and indexed_list_checker.

module tb_indexed_list_insert_delete_core;
    import ilid_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 300;
    localparam int RANDOM_WORDS = 1300;
    localparam int EPOCH_WORDS  = 160;
    localparam int SETTLE       = 8;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PULSE
    } sink_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned check_errors;
    int unsigned check_outstanding;
    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    bit          hold_done   = 1'b0;

    always #5 clk = ~clk;

    indexed_list_insert_delete_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (check_errors),
        .outstanding   (check_outstanding)
    );

    function automatic logic [IN_TDATA_W-1:0] pack_request(logic [OP_W-1:0] op,
                                                           logic [POS_W-1:0] pos,
                                                           logic [VAL_W-1:0] val);
        return IN_TDATA_W'({val, pos, op});
    endfunction

    task automatic offer_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(op, pos, val);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    initial
    begin : sink
        sink_mode_t  mode;
        int unsigned tick;
        mode = SINK_OPEN;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_sent >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (tick % 48 == 0)
                mode = sink_mode_t'($urandom_range(0, 3));
            tick++;
            case (mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ((tick % 8) < 5);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int unsigned      pick;
        int unsigned      n;
        bit               filling;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: read, delete and insert beyond the end all bounce
        offer_request(OP_READ,      8'd0,   $urandom());
        offer_request(OP_DELETE,    8'd0,   $urandom());
        offer_request(OP_INS_POS,   8'd1,   $urandom());
        // build up with extreme values, append by position equal to length
        offer_request(OP_INS_POS,   8'd0,   32'h7FFF_FFFF);
        offer_request(OP_INS_FRONT, 8'd255, 32'h8000_0000);
        offer_request(OP_INS_END,   8'd255, 32'hFFFF_FFFF);
        offer_request(OP_INS_END,   8'd0,   32'h0000_0000);
        offer_request(OP_INS_POS,   8'd2,   32'h5A5A_5A5A);
        offer_request(OP_INS_POS,   8'd5,   32'hA5A5_A5A5);
        offer_request(OP_INS_POS,   8'd255, $urandom());
        offer_request(OP_READ,      8'd0,   $urandom());
        offer_request(OP_READ,      8'd5,   $urandom());
        offer_request(OP_READ,      8'd6,   $urandom());
        offer_request(OP_READ,      8'd255, $urandom());
        offer_request(OP_DELETE,    8'd6,   $urandom());
        offer_request(OP_DELETE,    8'd255, $urandom());
        offer_request(OP_DELETE,    8'd0,   $urandom());
        offer_request(OP_DELETE,    8'd2,   $urandom());
        offer_request(OP_DELETE,    8'd3,   $urandom());
        offer_request(OP_SPARE_FIRST,         8'd255, 32'hFFFF_FFFF);
        offer_request(OP_SPARE_FIRST + 3'd1,  8'd0,   $urandom());
        offer_request(OP_SPARE_LAST,          8'd1,   $urandom());
        offer_request(OP_READ,      8'd2,   $urandom());

        // alternate epochs that fill the list to capacity and drain it again
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            filling = ((n / EPOCH_WORDS) % 2 == 0);
            pick = $urandom_range(0, 99);
            if (filling)
                op = (pick < 20) ? OP_READ :
                     (pick < 45) ? OP_INS_FRONT :
                     (pick < 70) ? OP_INS_END :
                     (pick < 85) ? OP_INS_POS :
                     (pick < 96) ? OP_DELETE :
                     OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else
                op = (pick < 20) ? OP_READ :
                     (pick < 30) ? OP_INS_FRONT :
                     (pick < 40) ? OP_INS_END :
                     (pick < 50) ? OP_INS_POS :
                     (pick < 96) ? OP_DELETE :
                     OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            pick = $urandom_range(0, 99);
            pos = (pick < 40) ? POS_W'($urandom_range(0, 3)) :
                  (pick < 85) ? POS_W'($urandom_range(0, CAPACITY + 2)) :
                  (pick < 95) ? POS_W'($urandom_range(CAPACITY - 4, CAPACITY + 1)) :
                  POS_W'($urandom_range(0, 255));
            offer_request(op, pos, $urandom());
        end
        s_axis_tvalid <= 1'b0;

        @(negedge clk);
        while (check_outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (check_errors == 0 && check_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_indexed_list_insert_delete_core

// File: filelist.f
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_cell.sv
hw/rtl/ilid_ctrl.sv
hw/rtl/indexed_list_insert_delete_core.sv
dv/indexed_list_checker.sv
dv/tb_indexed_list_insert_delete_core.sv
